// File: sv/kmsm_pkg.sv
// ============================================================================
// kmsm_pkg: shared definitions of the k-mismatch string matcher
// Widths, register indexes and the types passed between the cells, the
// scoring stage and the top level.
// ============================================================================
package kmsm_pkg;

   // Longest pattern the cell row can hold, one cell per pattern position.
   localparam int MAX_PATTERN = 32;
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 6;
   localparam int LEN_W       = 6;
   localparam int K_W         = 5;
   localparam int OCC_W       = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int PAT_REGS    = 4;
   localparam int BYTES_PER_REG = CSR_DATA_W / BYTE_W;

   // Saturated counter value, also the "no full window yet" mark.
   localparam logic [CNT_W-1:0] CNT_SAT = '1;

   typedef logic [CNT_W-1:0] count_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_0      = 3'd0,
      CSR_PATTERN_1      = 3'd1,
      CSR_PATTERN_2      = 3'd2,
      CSR_PATTERN_3      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4,
      CSR_MAX_MISMATCHES = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic step;   // a text beat is taken this cycle
      logic rearm;  // that beat ends the text
   } cell_ctrl_type;

   typedef struct packed {
      logic             match_here;
      logic [CNT_W-1:0] window_mismatches;
      logic [OCC_W-1:0] occurrence_total;
      logic             result_last;
   } rsp_type;

endpackage

// File: sv/kmsm_cell.sv
// ============================================================================
// kmsm_cell: one pattern position of the mismatch counter row
// Takes the count of its left neighbor, adds the mismatch of the new text
// byte against its own pattern byte and keeps the saturated sum.
// ============================================================================
module kmsm_cell
   import kmsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [BYTE_W-1:0] text_byte,
   input  logic [BYTE_W-1:0] pattern_byte,
   input  count_type         prev_count,
   output count_type         sum,
   output count_type         count
);

   logic       mismatch;
   logic [CNT_W:0] wide_sum;
   count_type  count_ff;
   count_type  count_in;

   assign mismatch = (text_byte != pattern_byte);
   assign wide_sum = {1'b0, prev_count} + {{CNT_W{1'b0}}, mismatch};
   assign sum      = wide_sum[CNT_W] ? CNT_SAT : wide_sum[CNT_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (ctrl.step) begin
         count_in = ctrl.rearm ? CNT_SAT : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_SAT;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// File: sv/kmsm_score.sv
// ============================================================================
// kmsm_score: window selection and occurrence count
// Picks the counter of the configured pattern length, decides the match,
// caps the shown distance and keeps the saturating occurrence count.
// ============================================================================
module kmsm_score
   import kmsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  count_type        sums [MAX_PATTERN],
   input  logic [LEN_W-1:0] pattern_length,
   input  logic [K_W-1:0]   max_mismatches,
   output rsp_type          result
);

   logic [IDX_W-1:0] sel_idx;
   count_type        window_count;
   count_type        cap;
   logic             hit;
   logic [OCC_W-1:0] occ_next;
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   // A length of zero acts as one, a length beyond the row as the full row.
   // The range check is one bit wider so that a row as long as the largest
   // length code still compares correctly.
   always_comb begin
      priority if (pattern_length == '0) begin
         sel_idx = '0;
      end else if ({1'b0, pattern_length} > (LEN_W + 1)'(MAX_PATTERN)) begin
         sel_idx = IDX_W'(MAX_PATTERN - 1);
      end else begin
         sel_idx = IDX_W'(pattern_length - LEN_W'(1));
      end
   end

   assign window_count = sums[sel_idx];
   assign cap          = {1'b0, max_mismatches} + count_type'(1);
   assign hit          = (window_count <= {1'b0, max_mismatches});
   assign occ_next     = (hit && (occ_ff != '1)) ? occ_ff + OCC_W'(1) : occ_ff;

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.step) begin
         occ_in = ctrl.rearm ? '0 : occ_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign result.match_here        = hit;
   assign result.window_mismatches = (window_count > cap) ? cap : window_count;
   assign result.occurrence_total  = occ_next;
   assign result.result_last       = ctrl.rearm;

   a_rearm_clears_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && ctrl.rearm) |=> (occ_ff == '0))
      else $error("occurrence count not cleared after the last beat of a text");

endmodule

// File: sv/k_mismatch_string_matcher_top.sv
// ============================================================================
// k_mismatch_string_matcher_top: streaming k-mismatch pattern search
// A row of counter cells tracks the mismatch count of every window length in
// parallel; one result beat follows each text beat.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   req_    | in        | valid / stall      | text_byte, text_last
//   rsp_    | out       | valid / stall      | match_here, window_mismatches,
//           |           |                    | occurrence_total, result_last
//   csr_    | in        | valid / ready      | index, data (write only)
//
// One text beat is taken every cycle while req_stall is low. Its result is
// computed in the cycle it is taken and appears on the rsp_ side from an
// output register backed by a one-entry skid register.
// Reset is synchronous and active high; it loads every cell with the
// saturated count, clears the occurrence count and restores register defaults.
// req_stall rises only while the skid register is occupied, so a held
// output lets the row take at most one more beat before it stops.
// Configuration writes are always taken; csr_ready is tied high.
//
// Each cell j holds the mismatch count of the last j+1 text bytes against
// pattern bytes 0..j. On a taken beat every cell loads its left neighbor's
// count plus its own byte mismatch, so counts march along the row by one
// position per beat. Cell 0 starts from zero. The count of the cell at the
// configured pattern length minus one is the distance of the window that ends
// at this byte; a text shorter than the pattern still sees the saturated
// count there and reports no match. A beat with text_last re-arms the row.
//
module k_mismatch_string_matcher_top
   import kmsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_text_byte,
   input  logic                  req_text_last,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_match_here,
   output logic [CNT_W-1:0]      rsp_window_mismatches,
   output logic [OCC_W-1:0]      rsp_occurrence_total,
   output logic                  rsp_result_last,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] pattern_ff [PAT_REGS];
   logic [CSR_DATA_W-1:0] pattern_in [PAT_REGS];
   logic [LEN_W-1:0]      length_ff;
   logic [LEN_W-1:0]      length_in;
   logic [K_W-1:0]        k_ff;
   logic [K_W-1:0]        k_in;

   // Handshake and result buffering.
   logic          req_take;
   logic          rsp_take;
   cell_ctrl_type ctrl;
   rsp_type       new_result;
   rsp_type       out_ff;
   rsp_type       out_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_type       skid_ff;
   rsp_type       skid_in;
   logic          skid_valid_ff;
   logic          skid_valid_in;

   // Cell row wiring.
   count_type     sums   [MAX_PATTERN];
   count_type     counts [MAX_PATTERN];

   assign csr_ready = 1'b1;

   // Register writes; indexes past the list are ignored.
   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      k_in       = k_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_0:      pattern_in[0] = csr_data;
            CSR_PATTERN_1:      pattern_in[1] = csr_data;
            CSR_PATTERN_2:      pattern_in[2] = csr_data;
            CSR_PATTERN_3:      pattern_in[3] = csr_data;
            CSR_PATTERN_LENGTH: length_in     = csr_data[LEN_W-1:0];
            CSR_MAX_MISMATCHES: k_in          = csr_data[K_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < PAT_REGS; r++) begin
            pattern_ff[r] <= '0;
         end
         length_ff <= LEN_W'(1);
         k_ff      <= '0;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
         k_ff       <= k_in;
      end
   end

   // The row advances on every taken text beat.
   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = out_valid_ff && !rsp_stall;
   assign ctrl.step  = req_take;
   assign ctrl.rearm = req_take && req_text_last;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      count_type         prev;
      logic [BYTE_W-1:0] pat_byte;

      if (j == 0) begin : g_head
         assign prev = '0;
      end else begin : g_link
         assign prev = counts[j-1];
      end

      // Pattern positions beyond the stored registers read as zero.
      if (j < PAT_REGS * BYTES_PER_REG) begin : g_pat
         assign pat_byte = pattern_ff[j / BYTES_PER_REG][(j % BYTES_PER_REG) * BYTE_W +: BYTE_W];
      end else begin : g_zero
         assign pat_byte = '0;
      end

      kmsm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .text_byte    (req_text_byte),
         .pattern_byte (pat_byte),
         .prev_count   (prev),
         .sum          (sums[j]),
         .count        (counts[j])
      );
   end

   kmsm_score u_score (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .sums           (sums),
      .pattern_length (length_ff),
      .max_mismatches (k_ff),
      .result         (new_result)
   );

   // Output register with a one-entry skid register behind it. A new result
   // lands in the skid register only when the output register is held.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_take) begin
            out_in       = new_result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_take) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall             = skid_valid_ff;
   assign rsp_valid             = out_valid_ff;
   assign rsp_match_here        = out_ff.match_here;
   assign rsp_window_mismatches = out_ff.window_mismatches;
   assign rsp_occurrence_total  = out_ff.occurrence_total;
   assign rsp_result_last       = out_ff.result_last;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_held_output_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && req_take) |=> skid_valid_ff)
      else $error("result of a taken beat lost behind a held output");

   a_match_counts: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.match_here) |-> (out_ff.occurrence_total != '0))
      else $error("match reported with a zero occurrence count");

endmodule

// File: sim/k_mismatch_string_matcher_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// k_mismatch_string_matcher_top_tb: self-checking bench for the matcher
// Streams text bytes into the matcher under several pattern settings and
// flow-control mixes. A beat-level model of the counter row predicts every
// result beat, and each beat is compared field by field against it.
// ============================================================================
module k_mismatch_string_matcher_top_tb;
   import kmsm_pkg::*;

   // The run is short. This limit only catches a hung handshake.
   localparam int CYCLE_LIMIT = 200000;

   // ------------------------------------------------------------------------
   // Clock, reset and the ports of the block. Every input starts at a known
   // value so that nothing is X while reset is held.
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_text_byte = '0;
   logic                  req_text_last = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_match_here;
   logic [CNT_W-1:0]      rsp_window_mismatches;
   logic [OCC_W-1:0]      rsp_occurrence_total;
   logic                  rsp_result_last;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   k_mismatch_string_matcher_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_text_byte         (req_text_byte),
      .req_text_last         (req_text_last),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_match_here        (rsp_match_here),
      .rsp_window_mismatches (rsp_window_mismatches),
      .rsp_occurrence_total  (rsp_occurrence_total),
      .rsp_result_last       (rsp_result_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // ------------------------------------------------------------------------
   // Shadow copy of the matcher: register values, one mismatch counter per
   // pattern position and the per-text occurrence count.
   // ------------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] pattern_regs [PAT_REGS];
   logic [LEN_W-1:0]      pattern_len;
   logic [K_W-1:0]        mismatch_limit;
   logic [CNT_W-1:0]      window_counts [MAX_PATTERN];
   logic [OCC_W-1:0]      occurrences_in_text;

   // Result beats predicted but not yet seen on the rsp_ side, oldest first.
   rsp_type pending_window_results [$];

   // Run statistics and the failure count.
   int fail_count      = 0;
   int cycle_count     = 0;
   int beats_sent      = 0;
   int texts_sent      = 0;
   int settings_used   = 0;
   int results_checked = 0;
   int matches_seen    = 0;

   // Flow-control mix of the current phase, in percent.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // When set, pattern and most text bytes come from a three-symbol alphabet
   // so that near matches and chance matches are frequent.
   bit         narrow_alphabet;
   logic [7:0] alphabet_extra;

   // Positions past the stored registers read as zero.
   function automatic logic [7:0] pattern_byte(input int pos);
      if (pos >= PAT_REGS * 8) return 8'h00;
      return pattern_regs[pos / 8][(pos % 8) * 8 +: 8];
   endfunction

   task automatic rearm_counters();
      for (int j = 0; j < MAX_PATTERN; j++) window_counts[j] = CNT_SAT;
      occurrences_in_text = '0;
   endtask

   task automatic reset_shadow();
      for (int r = 0; r < PAT_REGS; r++) pattern_regs[r] = '0;
      pattern_len    = LEN_W'(1);
      mismatch_limit = '0;
      rearm_counters();
   endtask

   // Advance the counter row by one text byte and queue the result beat that
   // the block must produce for it. Each counter takes its left neighbor's
   // count plus its own byte mismatch; position 0 starts from zero.
   task automatic predict_text_beat(input logic [7:0] text_byte, input logic text_last);
      rsp_type    outcome;
      int         sum;
      int         width_sel;
      int         cap;
      logic [5:0] sel;
      width_sel = (pattern_len == 0) ? 1 :
                  (pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len);
      for (int j = MAX_PATTERN - 1; j >= 1; j--) begin
         sum = int'(window_counts[j - 1]) + ((text_byte != pattern_byte(j)) ? 1 : 0);
         window_counts[j] = (sum > int'(CNT_SAT)) ? CNT_SAT : CNT_W'(sum);
      end
      window_counts[0] = (text_byte != pattern_byte(0)) ? CNT_W'(1) : CNT_W'(0);

      // A counter that is still saturated means the text is shorter than the
      // pattern; it is shown capped at k plus one and never matches.
      sel = window_counts[width_sel - 1];
      cap = int'(mismatch_limit) + 1;
      outcome.match_here        = (int'(sel) <= int'(mismatch_limit));
      outcome.window_mismatches = (int'(sel) > cap) ? CNT_W'(cap) : sel;
      if (outcome.match_here && occurrences_in_text != '1)
         occurrences_in_text = occurrences_in_text + 1'b1;
      outcome.occurrence_total = occurrences_in_text;
      outcome.result_last      = text_last;
      pending_window_results.push_back(outcome);
      if (text_last) rearm_counters();
   endtask

   // Every accepted text beat is predicted at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) predict_text_beat(req_text_byte, req_text_last);
   end

   // ------------------------------------------------------------------------
   // Result checking: each accepted result beat against the oldest
   // prediction. Only the first ten mismatches are printed.
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string what, input longint want, input longint got);
      fail_count++;
      if (fail_count <= 10)
         $display("Mismatch on %s at cycle %0d: expected %0h, got %0h",
                  what, cycle_count, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_window_results.size() == 0) begin
            note_mismatch("result beat with nothing pending", 0, 1);
         end else begin
            want = pending_window_results.pop_front();
            results_checked++;
            if (rsp_match_here) matches_seen++;
            if (rsp_match_here !== want.match_here)
               note_mismatch("match_here", want.match_here, rsp_match_here);
            if (rsp_window_mismatches !== want.window_mismatches)
               note_mismatch("window_mismatches", want.window_mismatches,
                             rsp_window_mismatches);
            if (rsp_occurrence_total !== want.occurrence_total)
               note_mismatch("occurrence_total", want.occurrence_total,
                             rsp_occurrence_total);
            if (rsp_result_last !== want.result_last)
               note_mismatch("result_last", want.result_last, rsp_result_last);
         end
      end
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < receiver_stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Drivers. All tasks are entered just after a falling edge, change inputs
   // there and watch handshakes at the rising edge.
   // ------------------------------------------------------------------------

   // One register write; the shadow copy takes the value at the same edge.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN_0, CSR_PATTERN_1, CSR_PATTERN_2, CSR_PATTERN_3: begin
            pattern_regs[int'(idx)] = value;
         end
         CSR_PATTERN_LENGTH: begin
            pattern_len = value[LEN_W-1:0];
         end
         CSR_MAX_MISMATCHES: begin
            mismatch_limit = value[K_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // Writes the whole register set. Only called while nothing is pending.
   task automatic apply_settings(input logic [255:0] pattern_image, input int len,
                                 input int k_value);
      write_register(CSR_PATTERN_0, pattern_image[63:0]);
      write_register(CSR_PATTERN_1, pattern_image[127:64]);
      write_register(CSR_PATTERN_2, pattern_image[191:128]);
      write_register(CSR_PATTERN_3, pattern_image[255:192]);
      write_register(CSR_PATTERN_LENGTH, CSR_DATA_W'(len));
      write_register(CSR_MAX_MISMATCHES, CSR_DATA_W'(k_value));
      csr_valid = 1'b0;
      settings_used++;
   endtask

   // Sends one text byte. Valid stays high on return so that back-to-back
   // beats never see it drop; idle gaps lower it before the next beat.
   task automatic send_text_beat(input logic [7:0] text_byte, input logic text_last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_text_byte = text_byte;
      req_text_last = text_last;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (text_last) texts_sent++;
      @(negedge clock);
   endtask

   // The sender holds off until every predicted result beat has arrived.
   task automatic wait_for_all_results();
      req_valid = 1'b0;
      while (pending_window_results.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Random stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic logic [7:0] noise_byte();
      if (narrow_alphabet && $urandom_range(4) != 0) begin
         case ($urandom_range(2))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return alphabet_extra;
         endcase
      end
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(255));
   endfunction

   function automatic int pick_length();
      case ($urandom_range(3))
         0:       return MAX_PATTERN;
         1:       return 1;
         default: return $urandom_range(MAX_PATTERN - 1, 2);
      endcase
   endfunction

   // k is mostly small against the length, sometimes zero, sometimes the
   // largest value and sometimes not below the pattern length.
   function automatic int pick_limit(input int len);
      case ($urandom_range(9))
         0, 1, 2: return 0;
         3:       return 31;
         4:       return $urandom_range(31, (len < 31) ? len : 31);
         default: return $urandom_range(len / 4, 0);
      endcase
   endfunction

   task automatic apply_random_settings(input int len, input int k_value);
      logic [255:0] image;
      narrow_alphabet = $urandom_range(1);
      alphabet_extra  = 8'($urandom_range(255));
      for (int i = 0; i < 32; i++) begin
         if (narrow_alphabet) begin
            case ($urandom_range(2))
               0:       image[i*8 +: 8] = 8'h00;
               1:       image[i*8 +: 8] = 8'hFF;
               default: image[i*8 +: 8] = alphabet_extra;
            endcase
         end else begin
            image[i*8 +: 8] = 8'($urandom_range(255));
         end
      end
      apply_settings(image, len, k_value);
   endtask

   // One text: noise mixed with planted copies of the pattern that carry a
   // few mutated bytes each, so windows land on both sides of k. Some texts
   // end before a full pattern length has arrived.
   task automatic send_random_text();
      logic [7:0] text_q [$];
      int         len;
      int         text_len;
      int         base;
      int         mutations;
      int         pos;
      len = int'(pattern_len);
      if ($urandom_range(9) == 0 && len > 1) text_len = $urandom_range(len - 1, 1);
      else text_len = $urandom_range(3 * len + 8, 1);
      while (text_q.size() < text_len) begin
         if ($urandom_range(2) == 0) begin
            base = text_q.size();
            for (int j = 0; j < len; j++) text_q.push_back(pattern_byte(j));
            mutations = $urandom_range(int'(mismatch_limit) + 2, 0);
            for (int m = 0; m < mutations; m++) begin
               pos = base + $urandom_range(len - 1, 0);
               text_q[pos] = text_q[pos] ^ 8'($urandom_range(255, 1));
            end
         end else begin
            text_q.push_back(noise_byte());
         end
      end
      while (text_q.size() > text_len) void'(text_q.pop_back());
      foreach (text_q[i]) send_text_beat(text_q[i], i == text_q.size() - 1);
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Register defaults after reset: a one-byte pattern of zero, exact match.
   task automatic test_reset_defaults();
      send_text_beat(8'h00, 1'b0);
      send_text_beat(8'h01, 1'b0);
      send_text_beat(8'h00, 1'b1);
      wait_for_all_results();
   endtask

   // A four-byte pattern with k of one: an exact window, a window one byte
   // off, a window two bytes off, and a text that ends before the pattern
   // length is reached.
   task automatic test_exact_and_near_windows();
      apply_settings(256'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210_0F1E_2D3C_4B5A_6978_8796_A5B4_7F80_FF00,
                     4, 1);
      send_text_beat(8'h00, 1'b0);
      send_text_beat(8'hFF, 1'b0);
      send_text_beat(8'h80, 1'b0);
      send_text_beat(8'h7F, 1'b0);
      send_text_beat(8'h00, 1'b0);
      send_text_beat(8'h01, 1'b0);
      send_text_beat(8'h80, 1'b0);
      send_text_beat(8'h7F, 1'b0);
      send_text_beat(8'hFE, 1'b0);
      send_text_beat(8'h01, 1'b0);
      send_text_beat(8'h80, 1'b0);
      send_text_beat(8'h7F, 1'b1);
      send_text_beat(8'h00, 1'b0);
      send_text_beat(8'hFF, 1'b1);
      wait_for_all_results();
   endtask

   // k not below the pattern length: every full window matches, while a text
   // shorter than the pattern still matches nothing.
   task automatic test_short_texts_and_wide_limit();
      apply_settings(256'h0, 1, 31);
      send_text_beat(8'h00, 1'b0);
      send_text_beat(8'hFF, 1'b1);
      wait_for_all_results();
      apply_settings(256'h0, 3, 5);
      send_text_beat(8'hFF, 1'b0);
      send_text_beat(8'h00, 1'b1);
      wait_for_all_results();
   endtask

   // One flow-control mix. Settings change now and then, always after the
   // sender has held off until every result has come back.
   task automatic run_traffic_phase(input int idle_pct, input int stall_pct, input int beats,
                                    input int first_len, input int first_limit);
      int start;
      int len;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      apply_random_settings(first_len, first_limit);
      start = beats_sent;
      while (beats_sent - start < beats) begin
         if ($urandom_range(7) == 0) begin
            wait_for_all_results();
            if ($urandom_range(1)) begin
               len = pick_length();
               apply_random_settings(len, pick_limit(len));
            end
         end
         send_random_text();
      end
      wait_for_all_results();
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(0, 0, 185, MAX_PATTERN, 0);
      run_traffic_phase(59, 0, 185, 1, 0);
      run_traffic_phase(0, 59, 185, 6, 2);
      run_traffic_phase(23, 23, 185, MAX_PATTERN, 31);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      reset_shadow();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_exact_and_near_windows();
      test_short_texts_and_wide_limit();
      test_random_traffic();

      // Wait for every pending result, then let the clock run on so that a
      // spurious extra beat would still be caught.
      wait_for_all_results();
      repeat (8) @(posedge clock);

      $display("Checked %0d result beats from %0d text bytes in %0d texts (%0d matches).",
               results_checked, beats_sent, texts_sent, matches_seen);
      $display("Used %0d register settings under four sender and receiver stall mixes.",
               settings_used);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches in total", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
